FILE: src/cjd_pkg.sv
// Shared types, codes and constants of the conveyor drive controller.
package cjd_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int SPEED_W    = 8;
	localparam int DUTY_W     = 8;
	localparam int SYM_W      = 2;
	localparam int DZ_W       = 7;
	localparam int DIVIDEND_W = 18;
	localparam int RECIP_W    = 19;
	localparam int QUOT_W     = 8;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [DZ_W-1:0]      DEAD_ZONE_RESET = 7'd10;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 8'sd100;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -8'sd100;
	localparam logic signed [SPEED_W:0]   JOY_OFFSET = 9'sd100;

	// reciprocals for truncating division by 1023 and by 100, exact over each dividend range
	localparam logic [RECIP_W-1:0] JOY_RECIP  = 19'd262401;
	localparam int                 JOY_SHIFT  = 28;
	localparam logic [RECIP_W-1:0] DUTY_RECIP = 19'd20972;
	localparam int                 DUTY_SHIFT = 21;

	// register index, taken from paddr[2]
	localparam logic REG_DEAD_ZONE = 1'b0;

	localparam logic [SYM_W-1:0] SYM_OFF  = 2'd0;
	localparam logic [SYM_W-1:0] SYM_IDLE = 2'd1;
	localparam logic [SYM_W-1:0] SYM_FWD  = 2'd2;
	localparam logic [SYM_W-1:0] SYM_REV  = 2'd3;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_IDLE,
		MODE_MANUAL,
		MODE_CONSTANT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_JDIV,
		ST_EVAL,
		ST_PDIV,
		ST_DONE
	} state_t;

	typedef enum logic {
		SCALE_JOY,
		SCALE_DUTY
	} scale_op_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		scale_op_t             op;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic              psel;
		logic              penable;
		logic              pwrite;
		logic [APB_AW-1:0] paddr;
		logic [APB_DW-1:0] pwdata;
	} apb_req_t;

endpackage

FILE: src/cjd_if.sv
// Valid/ready channel interfaces for drive requests and drive results.
interface cjd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  req_type;
	logic [cjd_pkg::SAMPLE_W-1:0]          joystick_sample;
	logic                                  click;
	logic                                  long_press;
	logic signed [cjd_pkg::SPEED_W-1:0]    command_speed;

	modport source (output valid, req_type, joystick_sample, click, long_press, command_speed,
		input ready);
	modport sink (input valid, req_type, joystick_sample, click, long_press, command_speed,
		output ready);
endinterface

interface cjd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [cjd_pkg::DUTY_W-1:0]            forward_pwm;
	logic [cjd_pkg::DUTY_W-1:0]            reverse_pwm;
	logic [cjd_pkg::SYM_W-1:0]             symbol_code;
	logic signed [cjd_pkg::SPEED_W-1:0]    current_speed;
	logic                                  running;

	modport source (output valid, forward_pwm, reverse_pwm, symbol_code, current_speed, running,
		input ready);
	modport sink (input valid, forward_pwm, reverse_pwm, symbol_code, current_speed, running,
		output ready);
endinterface

FILE: src/cjd_div.sv
// Shared reciprocal scaler: truncated division by 1023 or 100, result in the cycle after start.
module cjd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cjd_pkg::div_req_t req,
	output cjd_pkg::div_rsp_t rsp
);
	localparam int PROD_W = cjd_pkg::DIVIDEND_W + cjd_pkg::RECIP_W;

	logic [cjd_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0]           prod;
	logic [cjd_pkg::QUOT_W-1:0]  quot;
	logic [cjd_pkg::QUOT_W-1:0]  quot_q;
	logic                        done_q;

	assign recip = (req.op == cjd_pkg::SCALE_JOY) ? cjd_pkg::JOY_RECIP : cjd_pkg::DUTY_RECIP;
	assign prod  = PROD_W'(req.dividend) * PROD_W'(recip);
	// quotient never exceeds 8 bits for either dividend range
	assign quot  = (req.op == cjd_pkg::SCALE_JOY) ? prod[cjd_pkg::JOY_SHIFT +: cjd_pkg::QUOT_W]
		: prod[cjd_pkg::DUTY_SHIFT +: cjd_pkg::QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= quot;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

FILE: src/cjd_cfg.sv
// APB register file holding the joystick dead zone.
module cjd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cjd_pkg::apb_req_t            apb,
	output logic [cjd_pkg::APB_DW-1:0]   prdata,
	output logic [cjd_pkg::DZ_W-1:0]     dead_zone
);
	logic [cjd_pkg::DZ_W-1:0] dead_zone_q;
	logic                     wr_en;

	assign wr_en = apb.psel && apb.penable && apb.pwrite
		&& apb.paddr[2] == cjd_pkg::REG_DEAD_ZONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= cjd_pkg::DEAD_ZONE_RESET;
		end else if (wr_en) begin
			dead_zone_q <= apb.pwdata[cjd_pkg::DZ_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (apb.paddr[2])
			cjd_pkg::REG_DEAD_ZONE: prdata = {{(cjd_pkg::APB_DW-cjd_pkg::DZ_W){1'b0}}, dead_zone_q};
			default: prdata = '0;
		endcase
	end

	assign dead_zone = dead_zone_q;
endmodule

FILE: src/conveyor_joystick_drive_control_unit.sv
// Top level of the conveyor drive controller: sequencer, drive state and result register.
//
//  channel   | dir | handshake              | contents
//  in_ch     | in  | valid/ready            | req_type, joystick_sample, click, long_press,
//            |     |                        | command_speed
//  out_ch    | out | valid/ready            | forward_pwm, reverse_pwm, symbol_code,
//            |     |                        | current_speed, running
//  APB       | in  | psel/penable, pready=1 | dead_zone at byte address 0
//
// A tick that recomputes the duty runs through joystick scaling, evaluation, duty scaling and
// result load, with the result valid once it is loaded into the output register. A tick
// without a new duty skips the duty scaling, and a command goes straight to the result load.
// Both scalings share one reciprocal multiplier. in_ch.ready is high only while idle.
// A result waiting in the output register holds the sequencer in its final step until the
// slot frees, so one more transaction can be accepted behind it. Reset is async, active low.
module conveyor_joystick_drive_control_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	cjd_in_if.sink                             in_ch,
	cjd_out_if.source                          out_ch,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cjd_pkg::APB_AW-1:0]         paddr,
	input  logic [cjd_pkg::APB_DW-1:0]         pwdata,
	output logic [cjd_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);
	localparam int SW = cjd_pkg::SPEED_W;

	cjd_pkg::apb_req_t apb;
	cjd_pkg::div_req_t div_req;
	cjd_pkg::div_rsp_t div_rsp;
	logic [cjd_pkg::DZ_W-1:0] dead_zone;

	cjd_pkg::state_t state_q, state_d;
	cjd_pkg::mode_t  mode_q, mode_d;
	logic signed [SW-1:0] speed_q, speed_d;
	logic signed [SW-1:0] held_q, held_d;
	logic                 pend_q, pend_d;
	logic [cjd_pkg::DUTY_W-1:0] fwd_q, fwd_d, rev_q, rev_d;
	logic [cjd_pkg::SYM_W-1:0]  sym_q, sym_d;
	logic click_q, lp_q;

	logic out_valid_q;
	logic out_load;
	logic in_acc;

	// eval helpers
	cjd_pkg::mode_t       mode_lp;
	logic                 pend_c;
	logic signed [SW:0]   jv;
	logic [SW:0]          jabs;
	logic signed [SW-1:0] js;
	logic signed [SW-1:0] drv;
	logic [SW-1:0]        dabs;
	logic [SW-2:0]        dmag;
	logic [14:0]          duty_num;
	logic signed [SW-1:0] cmd_v;
	logic [cjd_pkg::SAMPLE_W-1:0] samp;

	assign apb = '{psel: psel, penable: penable, pwrite: pwrite, paddr: paddr, pwdata: pwdata};
	assign pready = 1'b1;

	cjd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.apb       (apb),
		.prdata    (prdata),
		.dead_zone (dead_zone)
	);

	cjd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ch.ready = (state_q == cjd_pkg::ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign samp        = in_ch.joystick_sample;

	// joystick speed from the first scaling
	assign jv   = $signed({1'b0, div_rsp.quot}) - cjd_pkg::JOY_OFFSET;
	assign jabs = jv[SW] ? (SW+1)'(-jv) : jv;
	assign js   = (jabs < {2'b00, dead_zone}) ? '0 : jv[SW-1:0];

	assign mode_lp = lp_q ? ((mode_q == cjd_pkg::MODE_OFF) ? cjd_pkg::MODE_IDLE
		: cjd_pkg::MODE_OFF) : mode_q;
	assign pend_c  = pend_q | click_q;

	// speed to drive: manual uses the joystick, constant the latched value
	assign drv      = (mode_lp == cjd_pkg::MODE_MANUAL) ? js : held_q;
	assign dabs     = drv[SW-1] ? SW'(-drv) : drv;
	assign dmag     = dabs[SW-2:0];
	assign duty_num = {dmag, 8'h00} - {8'h00, dmag};

	assign cmd_v = (in_ch.command_speed > cjd_pkg::SPEED_MAX) ? cjd_pkg::SPEED_MAX
		: (in_ch.command_speed < cjd_pkg::SPEED_MIN) ? cjd_pkg::SPEED_MIN
		: in_ch.command_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cjd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		speed_d  = speed_q;
		held_d   = held_q;
		pend_d   = pend_q;
		fwd_d    = fwd_q;
		rev_d    = rev_q;
		sym_d    = sym_q;
		out_load = 1'b0;
		div_req  = '{start: 1'b0, dividend: '0, op: cjd_pkg::SCALE_JOY};
		unique case (state_q)
			cjd_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_ch.req_type) begin
						if (mode_q != cjd_pkg::MODE_OFF) begin
							speed_d = cmd_v;
							held_d  = cmd_v;
							mode_d  = (cmd_v == '0) ? cjd_pkg::MODE_IDLE : cjd_pkg::MODE_CONSTANT;
						end
						state_d = cjd_pkg::ST_DONE;
					end else begin
						// s*200 as shifts
						div_req.start    = 1'b1;
						div_req.dividend = {1'b0, samp, 7'b0} + {2'b0, samp, 6'b0}
							+ {5'b0, samp, 3'b0};
						div_req.op       = cjd_pkg::SCALE_JOY;
						state_d = cjd_pkg::ST_JDIV;
					end
				end
			end
			cjd_pkg::ST_JDIV: begin
				if (div_rsp.done) begin
					state_d = cjd_pkg::ST_EVAL;
				end
			end
			cjd_pkg::ST_EVAL: begin
				state_d = cjd_pkg::ST_DONE;
				pend_d  = pend_c;
				mode_d  = mode_lp;
				unique case (mode_lp)
					cjd_pkg::MODE_OFF: begin
						speed_d = '0;
						fwd_d   = '0;
						rev_d   = '0;
						sym_d   = cjd_pkg::SYM_OFF;
						pend_d  = 1'b0;
					end
					cjd_pkg::MODE_IDLE: begin
						speed_d = '0;
						fwd_d   = '0;
						rev_d   = '0;
						sym_d   = cjd_pkg::SYM_IDLE;
						pend_d  = 1'b0;
						if (js != '0) begin
							mode_d = cjd_pkg::MODE_MANUAL;
						end
					end
					cjd_pkg::MODE_MANUAL: begin
						speed_d = js;
						if (js == '0) begin
							mode_d = cjd_pkg::MODE_IDLE;
						end else if (pend_c) begin
							pend_d = 1'b0;
							held_d = js;
							mode_d = cjd_pkg::MODE_CONSTANT;
						end else begin
							sym_d   = (js > 0) ? cjd_pkg::SYM_FWD : cjd_pkg::SYM_REV;
							state_d = cjd_pkg::ST_PDIV;
						end
					end
					cjd_pkg::MODE_CONSTANT: begin
						speed_d = held_q;
						if (pend_c) begin
							pend_d  = 1'b0;
							speed_d = '0;
							held_d  = '0;
							mode_d  = cjd_pkg::MODE_IDLE;
						end else begin
							sym_d = (held_q > 0) ? cjd_pkg::SYM_FWD : cjd_pkg::SYM_REV;
							if (held_q == '0) begin
								fwd_d = '0;
								rev_d = '0;
							end else begin
								state_d = cjd_pkg::ST_PDIV;
							end
						end
					end
					default: state_d = cjd_pkg::ST_DONE;
				endcase
				if (state_d == cjd_pkg::ST_PDIV) begin
					div_req.start    = 1'b1;
					div_req.dividend = {3'b000, duty_num};
					div_req.op       = cjd_pkg::SCALE_DUTY;
				end
			end
			cjd_pkg::ST_PDIV: begin
				if (div_rsp.done) begin
					if (speed_q > 0) begin
						fwd_d = div_rsp.quot;
						rev_d = '0;
					end else begin
						fwd_d = '0;
						rev_d = div_rsp.quot;
					end
					state_d = cjd_pkg::ST_DONE;
				end
			end
			cjd_pkg::ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = cjd_pkg::ST_IDLE;
				end
			end
			default: state_d = cjd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= cjd_pkg::MODE_OFF;
			speed_q     <= '0;
			held_q      <= '0;
			pend_q      <= 1'b0;
			fwd_q       <= '0;
			rev_q       <= '0;
			sym_q       <= cjd_pkg::SYM_OFF;
			out_valid_q <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			speed_q <= speed_d;
			held_q  <= held_d;
			pend_q  <= pend_d;
			fwd_q   <= fwd_d;
			rev_q   <= rev_d;
			sym_q   <= sym_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			click_q <= in_ch.click;
			lp_q    <= in_ch.long_press;
		end
		if (out_load) begin
			out_ch.forward_pwm   <= fwd_q;
			out_ch.reverse_pwm   <= rev_q;
			out_ch.symbol_code   <= sym_q;
			out_ch.current_speed <= speed_q;
			out_ch.running       <= (mode_q != cjd_pkg::MODE_OFF);
		end
	end

	assign out_ch.valid = out_valid_q;
endmodule

FILE: src/cjd_chk.sv
// Port-level checker for the conveyor drive controller, bound to the top level.
module cjd_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cjd_pkg::DUTY_W-1:0]      forward_pwm,
	input logic [cjd_pkg::DUTY_W-1:0]      reverse_pwm,
	input logic [cjd_pkg::SYM_W-1:0]       symbol_code,
	input logic signed [cjd_pkg::SPEED_W-1:0] current_speed,
	input logic                            running
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(forward_pwm)
			&& $stable(reverse_pwm) && $stable(symbol_code)
			&& $stable(current_speed) && $stable(running))
		else $error("result changed while stalled");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in progress");

	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> forward_pwm == '0 && reverse_pwm == '0
			&& symbol_code == cjd_pkg::SYM_OFF && current_speed == '0)
		else $error("drive active while off");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_speed <= cjd_pkg::SPEED_MAX
			&& current_speed >= cjd_pkg::SPEED_MIN)
		else $error("speed out of range");

	// the idle line of the motor matches the symbol shown
	a_sym_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (symbol_code == cjd_pkg::SYM_FWD && reverse_pwm == '0)
			|| (symbol_code == cjd_pkg::SYM_REV && forward_pwm == '0)
			|| (forward_pwm == '0 && reverse_pwm == '0))
		else $error("duty inconsistent with symbol");
endmodule

bind conveyor_joystick_drive_control_unit cjd_chk u_cjd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.forward_pwm   (out_ch.forward_pwm),
	.reverse_pwm   (out_ch.reverse_pwm),
	.symbol_code   (out_ch.symbol_code),
	.current_speed (out_ch.current_speed),
	.running       (out_ch.running)
);
